// ===== rtl/trigger_rest_calibration_map_unit_assert.svh =====
// assertion macros for the trigger rest calibration map unit
`ifndef TRIGGER_REST_CALIBRATION_MAP_UNIT_ASSERT_SVH
`define TRIGGER_REST_CALIBRATION_MAP_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TRCM_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("trcm check failed");

// next-cycle implication, checked out of reset
`define TRCM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("trcm check failed");

`endif

// ===== rtl/trcm_pkg.sv =====
// types, register codes and constants for the trigger rest calibration map unit
`timescale 1ns / 1ps

package trcm_pkg;

   localparam logic [2:0] CSR_REST_MARGIN       = 3'd0;
   localparam logic [2:0] CSR_ARM_THRESHOLD     = 3'd1;
   localparam logic [2:0] CSR_ZERO_REST_ARM_RAW = 3'd2;
   localparam logic [2:0] CSR_STABLE_SPREAD     = 3'd3;
   localparam logic [2:0] CSR_CALIB_WINDOW_MS   = 3'd4;
   localparam logic [2:0] CSR_ZERO_REST_MS      = 3'd5;
   localparam logic [2:0] CSR_MAX_CURRENT_MA    = 3'd6;
   localparam logic [2:0] CSR_MAX_SPEED_RPM     = 3'd7;

   localparam logic [7:0]  RST_REST_MARGIN       = 8'd8;
   localparam logic [7:0]  RST_ARM_THRESHOLD     = 8'd20;
   localparam logic [7:0]  RST_ZERO_REST_ARM_RAW = 8'd20;
   localparam logic [7:0]  RST_STABLE_SPREAD     = 8'd6;
   localparam logic [15:0] RST_CALIB_WINDOW_MS   = 16'd500;
   localparam logic [15:0] RST_ZERO_REST_MS      = 16'd500;
   localparam logic [15:0] RST_MAX_CURRENT_MA    = 16'd10000;
   localparam logic [15:0] RST_MAX_SPEED_RPM     = 16'd10000;

   localparam logic [7:0] STABLE_MAX_IDLE = 8'd64;
   localparam logic [7:0] ANALOG_REST_MIN = 8'd1;
   localparam logic [7:0] REST_UNKNOWN    = 8'd255;
   localparam logic [7:0] FULL_SCALE      = 8'd255;
   localparam logic [9:0] GATE_PAD        = 10'd4;

   localparam logic CMD_SAMPLE  = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   typedef struct packed {
      logic [7:0]  rest_margin;
      logic [7:0]  arm_threshold;
      logic [7:0]  zero_rest_arm_raw;
      logic [7:0]  stable_spread;
      logic [15:0] calib_window_ms;
      logic [15:0] zero_rest_ms;
      logic [15:0] max_current_ma;
      logic [15:0] max_speed_rpm;
   } cfg_type;

   typedef struct packed {
      logic       calibrated;
      logic [7:0] rest_level;
      logic [7:0] effective;
      logic       armed;
      logic [7:0] travel;
      logic [7:0] span;
      logic [7:0] range;
   } job_type;

   typedef struct packed {
      logic        calibrated;
      logic [7:0]  rest_level;
      logic [7:0]  effective;
      logic        armed;
      logic [7:0]  travel;
      logic [15:0] current_target_ma;
      logic [15:0] speed_target_rpm;
   } rsp_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_DIV,
      BACK_DONE
   } back_state_type;

endpackage

// ===== rtl/trcm_fifo.sv =====
// small first-in first-out queue with show-ahead head
`timescale 1ns / 1ps

module trcm_fifo #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/trcm_front.sv =====
// front end: calibration state update and travel classification per item
`timescale 1ns / 1ps

module trcm_front (
   input  logic              clock,
   input  logic              reset,
   input  trcm_pkg::cfg_type cfg,
   input  logic              item_take,
   input  logic              cmd,
   input  logic [7:0]        sample,
   input  logic [31:0]       time_ms,
   output trcm_pkg::job_type job
);

   logic        is_calibrated_ff, is_calibrated_in;
   logic [7:0]  rest_value_ff, rest_value_in;
   logic        zero_run_open_ff, zero_run_open_in;
   logic [31:0] zero_run_start_ff, zero_run_start_in;
   logic        stable_open_ff, stable_open_in;
   logic [31:0] stable_start_ff, stable_start_in;
   logic [7:0]  stable_low_ff, stable_low_in;
   logic [7:0]  stable_high_ff, stable_high_in;

   // state update
   always_comb begin
      logic [9:0]  gate_sum;
      logic [7:0]  gate;
      logic [12:0] avg;
      logic [8:0]  lo_sum;
      logic [8:0]  hi_sum;
      logic [7:0]  new_lo;
      logic [7:0]  new_hi;
      logic [31:0] zero_age;
      logic [31:0] stable_age;

      is_calibrated_in  = is_calibrated_ff;
      rest_value_in     = rest_value_ff;
      zero_run_open_in  = zero_run_open_ff;
      zero_run_start_in = zero_run_start_ff;
      stable_open_in    = stable_open_ff;
      stable_start_in   = stable_start_ff;
      stable_low_in     = stable_low_ff;
      stable_high_in    = stable_high_ff;

      gate_sum   = {2'b0, rest_value_ff} + {2'b0, cfg.rest_margin} + trcm_pkg::GATE_PAD;
      gate       = (gate_sum > {2'b0, trcm_pkg::FULL_SCALE}) ? trcm_pkg::FULL_SCALE
                                                             : gate_sum[7:0];
      avg        = ({rest_value_ff, 5'b0} - {5'b0, rest_value_ff}) + {5'b0, sample};
      lo_sum     = {1'b0, sample} + {1'b0, cfg.stable_spread};
      hi_sum     = {1'b0, stable_high_ff} + {1'b0, cfg.stable_spread};
      new_lo     = (sample < stable_low_ff) ? sample : stable_low_ff;
      new_hi     = (sample > stable_high_ff) ? sample : stable_high_ff;
      zero_age   = time_ms - zero_run_start_ff;
      stable_age = time_ms - stable_start_ff;

      if (cmd == trcm_pkg::CMD_RESTART) begin
         is_calibrated_in  = 1'b0;
         rest_value_in     = trcm_pkg::REST_UNKNOWN;
         zero_run_open_in  = 1'b0;
         zero_run_start_in = '0;
         stable_open_in    = 1'b0;
         stable_start_in   = '0;
         stable_low_in     = 8'hFF;
         stable_high_in    = '0;
      end else if (is_calibrated_ff) begin
         // rest tracking average
         if (sample <= gate && !(rest_value_ff == '0 && sample == '0)) begin
            rest_value_in = avg[12:5];
         end
      end else if (sample == '0) begin
         stable_open_in = 1'b0;
         if (!zero_run_open_ff) begin
            zero_run_open_in  = 1'b1;
            zero_run_start_in = time_ms;
         end else if (zero_age >= {16'b0, cfg.zero_rest_ms}) begin
            rest_value_in    = '0;
            is_calibrated_in = 1'b1;
            zero_run_open_in = 1'b0;
         end
      end else begin
         zero_run_open_in = 1'b0;
         if (sample >= trcm_pkg::ANALOG_REST_MIN) begin
            if (!stable_open_ff || lo_sum < {1'b0, stable_low_ff}
                || {1'b0, sample} > hi_sum) begin
               stable_open_in  = 1'b1;
               stable_start_in = time_ms;
               stable_low_in   = sample;
               stable_high_in  = sample;
            end else begin
               stable_low_in  = new_lo;
               stable_high_in = new_hi;
               if (stable_age >= {16'b0, cfg.calib_window_ms}) begin
                  if ((new_hi - new_lo) <= cfg.stable_spread
                      && new_hi <= trcm_pkg::STABLE_MAX_IDLE) begin
                     rest_value_in    = new_lo;
                     is_calibrated_in = 1'b1;
                  end
                  stable_open_in = 1'b0;
               end
            end
         end
      end
   end

   // classification against the updated state
   always_comb begin
      logic [8:0] base;
      logic [8:0] eff_diff;
      logic [7:0] eff;
      logic       rest_at_zero;
      logic [7:0] trav;
      logic [7:0] floor_t;

      base         = {1'b0, rest_value_in} + {1'b0, cfg.rest_margin};
      eff_diff     = {1'b0, sample} - base;
      eff          = ({1'b0, sample} <= base) ? '0 : eff_diff[7:0];
      rest_at_zero = is_calibrated_in && (rest_value_in == '0);
      if (rest_at_zero) begin
         trav = (sample <= cfg.zero_rest_arm_raw) ? '0 : sample - cfg.zero_rest_arm_raw;
      end else begin
         trav = eff;
      end
      floor_t = rest_at_zero ? '0 : cfg.arm_threshold;

      job.calibrated = is_calibrated_in;
      job.rest_level = rest_value_in;
      job.effective  = eff;
      if (!is_calibrated_in) begin
         job.armed = 1'b0;
      end else if (rest_value_in == '0) begin
         job.armed = (sample >= cfg.zero_rest_arm_raw);
      end else begin
         job.armed = (eff >= cfg.arm_threshold);
      end
      job.travel = trav;
      job.span   = (trav >= floor_t) ? trav - floor_t : '0;
      job.range  = trcm_pkg::FULL_SCALE - floor_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_calibrated_ff  <= 1'b0;
         rest_value_ff     <= trcm_pkg::REST_UNKNOWN;
         zero_run_open_ff  <= 1'b0;
         zero_run_start_ff <= '0;
         stable_open_ff    <= 1'b0;
         stable_start_ff   <= '0;
         stable_low_ff     <= 8'hFF;
         stable_high_ff    <= '0;
      end else if (item_take) begin
         is_calibrated_ff  <= is_calibrated_in;
         rest_value_ff     <= rest_value_in;
         zero_run_open_ff  <= zero_run_open_in;
         zero_run_start_ff <= zero_run_start_in;
         stable_open_ff    <= stable_open_in;
         stable_start_ff   <= stable_start_in;
         stable_low_ff     <= stable_low_in;
         stable_high_ff    <= stable_high_in;
      end
   end

endmodule

// ===== rtl/trcm_back.sv =====
// back end: current and speed targets by multiply and serial divide
`timescale 1ns / 1ps

module trcm_back (
   input  logic              clock,
   input  logic              reset,
   input  trcm_pkg::cfg_type cfg,
   input  logic              job_empty,
   input  trcm_pkg::job_type job_data,
   output logic              job_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output trcm_pkg::rsp_type rsp_data
);

   trcm_pkg::back_state_type state_ff, state_in;
   trcm_pkg::job_type        job_ff, job_in;
   logic [7:0]               rem_cur_ff, rem_cur_in;
   logic [7:0]               rem_spd_ff, rem_spd_in;
   logic [15:0]              quo_cur_ff, quo_cur_in;
   logic [15:0]              quo_spd_ff, quo_spd_in;
   logic [3:0]               count_ff, count_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         trcm_pkg::BACK_IDLE: begin
            if (!job_empty) begin
               state_in = trcm_pkg::BACK_MUL;
            end
         end
         trcm_pkg::BACK_MUL: begin
            state_in = trcm_pkg::BACK_DIV;
         end
         trcm_pkg::BACK_DIV: begin
            if (count_ff == 4'd15) begin
               state_in = trcm_pkg::BACK_DONE;
            end
         end
         trcm_pkg::BACK_DONE: begin
            if (!rsp_full) begin
               state_in = trcm_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = trcm_pkg::BACK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      job_pop  = 1'b0;
      rsp_push = 1'b0;
      case (state_ff)
         trcm_pkg::BACK_IDLE: begin
            job_pop = !job_empty;
         end
         trcm_pkg::BACK_DONE: begin
            rsp_push = !rsp_full;
         end
         default: begin
            job_pop  = 1'b0;
            rsp_push = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      logic [23:0] prod_cur;
      logic [23:0] prod_spd;
      logic [8:0]  sh_cur;
      logic [8:0]  sh_spd;
      logic [8:0]  div9;

      job_in     = job_ff;
      rem_cur_in = rem_cur_ff;
      rem_spd_in = rem_spd_ff;
      quo_cur_in = quo_cur_ff;
      quo_spd_in = quo_spd_ff;
      count_in   = count_ff;

      prod_cur = 24'(job_ff.span) * 24'(cfg.max_current_ma);
      prod_spd = 24'(job_ff.span) * 24'(cfg.max_speed_rpm);
      sh_cur   = {rem_cur_ff, quo_cur_ff[15]};
      sh_spd   = {rem_spd_ff, quo_spd_ff[15]};
      div9     = {1'b0, job_ff.range};

      case (state_ff)
         trcm_pkg::BACK_IDLE: begin
            if (!job_empty) begin
               job_in = job_data;
            end
         end
         trcm_pkg::BACK_MUL: begin
            // upper byte of the product is below the range since span <= range
            rem_cur_in = prod_cur[23:16];
            quo_cur_in = prod_cur[15:0];
            rem_spd_in = prod_spd[23:16];
            quo_spd_in = prod_spd[15:0];
            count_in   = '0;
         end
         trcm_pkg::BACK_DIV: begin
            if (sh_cur >= div9) begin
               rem_cur_in = 8'(sh_cur - div9);
               quo_cur_in = {quo_cur_ff[14:0], 1'b1};
            end else begin
               rem_cur_in = sh_cur[7:0];
               quo_cur_in = {quo_cur_ff[14:0], 1'b0};
            end
            if (sh_spd >= div9) begin
               rem_spd_in = 8'(sh_spd - div9);
               quo_spd_in = {quo_spd_ff[14:0], 1'b1};
            end else begin
               rem_spd_in = sh_spd[7:0];
               quo_spd_in = {quo_spd_ff[14:0], 1'b0};
            end
            count_in = count_ff + 1'b1;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_comb begin
      rsp_data.calibrated        = job_ff.calibrated;
      rsp_data.rest_level        = job_ff.rest_level;
      rsp_data.effective         = job_ff.effective;
      rsp_data.armed             = job_ff.armed;
      rsp_data.travel            = job_ff.travel;
      // empty range maps to zero
      rsp_data.current_target_ma = (job_ff.range == '0) ? '0 : quo_cur_ff;
      rsp_data.speed_target_rpm  = (job_ff.range == '0) ? '0 : quo_spd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trcm_pkg::BACK_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      rem_cur_ff <= rem_cur_in;
      rem_spd_ff <= rem_spd_in;
      quo_cur_ff <= quo_cur_in;
      quo_spd_ff <= quo_spd_in;
   end

endmodule

// ===== rtl/trigger_rest_calibration_map_unit.sv =====
// top level of the trigger rest calibration and travel map unit
//
// Input queue side: req_push with req_cmd, req_sample, req_time_ms; an item is
// taken at a clock edge with req_push high and req_full low. req_cmd restart
// clears calibration; sample items update the learned rest level.
// Result queue side: while rsp_empty is low the oldest result is on the rsp_
// ports; it is taken at an edge with rsp_pop high.
// The front end updates calibration and classifies the item in the cycle it is
// taken, then queues it. The back end forms span * max / range for current and
// speed with a multiply step followed by a 16-step restoring divider, two lanes.
// With queues empty an item passes the job queue, the back end's idle, multiply,
// divide and done states and the result queue before it reaches the rsp_ ports.
// The back end takes a new item only after it has pushed the last result.
// Both queues hold QUEUE_DEPTH entries; a stalled receiver fills the result
// queue, then the job queue, and then req_full rises.
// Reset (synchronous, high) empties both queues, clears calibration and loads
// the register defaults. csr_ writes take effect at once; write while idle.
`timescale 1ns / 1ps

`include "trigger_rest_calibration_map_unit_assert.svh"

module trigger_rest_calibration_map_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_cmd,
   input  logic [7:0]  req_sample,
   input  logic [31:0] req_time_ms,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_calibrated,
   output logic [7:0]  rsp_rest_level,
   output logic [7:0]  rsp_effective,
   output logic        rsp_armed,
   output logic [7:0]  rsp_travel,
   output logic [15:0] rsp_current_target_ma,
   output logic [15:0] rsp_speed_target_rpm,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   trcm_pkg::cfg_type cfg_ff;
   trcm_pkg::job_type front_job;
   trcm_pkg::job_type mid_job;
   trcm_pkg::rsp_type back_rsp;
   trcm_pkg::rsp_type out_rsp;
   logic              item_take;
   logic              mid_full;
   logic              mid_empty;
   logic              mid_pop;
   logic              out_full;
   logic              out_push;

   assign req_full  = mid_full;
   assign item_take = req_push && !mid_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rest_margin       <= trcm_pkg::RST_REST_MARGIN;
         cfg_ff.arm_threshold     <= trcm_pkg::RST_ARM_THRESHOLD;
         cfg_ff.zero_rest_arm_raw <= trcm_pkg::RST_ZERO_REST_ARM_RAW;
         cfg_ff.stable_spread     <= trcm_pkg::RST_STABLE_SPREAD;
         cfg_ff.calib_window_ms   <= trcm_pkg::RST_CALIB_WINDOW_MS;
         cfg_ff.zero_rest_ms      <= trcm_pkg::RST_ZERO_REST_MS;
         cfg_ff.max_current_ma    <= trcm_pkg::RST_MAX_CURRENT_MA;
         cfg_ff.max_speed_rpm     <= trcm_pkg::RST_MAX_SPEED_RPM;
      end else if (csr_write_en) begin
         case (csr_index)
            trcm_pkg::CSR_REST_MARGIN:       cfg_ff.rest_margin       <= csr_wdata[7:0];
            trcm_pkg::CSR_ARM_THRESHOLD:     cfg_ff.arm_threshold     <= csr_wdata[7:0];
            trcm_pkg::CSR_ZERO_REST_ARM_RAW: cfg_ff.zero_rest_arm_raw <= csr_wdata[7:0];
            trcm_pkg::CSR_STABLE_SPREAD:     cfg_ff.stable_spread     <= csr_wdata[7:0];
            trcm_pkg::CSR_CALIB_WINDOW_MS:   cfg_ff.calib_window_ms   <= csr_wdata;
            trcm_pkg::CSR_ZERO_REST_MS:      cfg_ff.zero_rest_ms      <= csr_wdata;
            trcm_pkg::CSR_MAX_CURRENT_MA:    cfg_ff.max_current_ma    <= csr_wdata;
            trcm_pkg::CSR_MAX_SPEED_RPM:     cfg_ff.max_speed_rpm     <= csr_wdata;
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   trcm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .item_take (item_take),
      .cmd       (req_cmd),
      .sample    (req_sample),
      .time_ms   (req_time_ms),
      .job       (front_job)
   );

   trcm_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(trcm_pkg::job_type))
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_job),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_job),
      .empty     (mid_empty)
   );

   trcm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (mid_empty),
      .job_data  (mid_job),
      .job_pop   (mid_pop),
      .rsp_full  (out_full),
      .rsp_push  (out_push),
      .rsp_data  (back_rsp)
   );

   trcm_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(trcm_pkg::rsp_type))
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_rsp),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_rsp),
      .empty     (rsp_empty)
   );

   assign rsp_calibrated        = out_rsp.calibrated;
   assign rsp_rest_level        = out_rsp.rest_level;
   assign rsp_effective         = out_rsp.effective;
   assign rsp_armed             = out_rsp.armed;
   assign rsp_travel            = out_rsp.travel;
   assign rsp_current_target_ma = out_rsp.current_target_ma;
   assign rsp_speed_target_rpm  = out_rsp.speed_target_rpm;

   `TRCM_ASSERT_NEXT(a_take_queues_job, clock, reset, item_take, !mid_empty)
   `TRCM_ASSERT_NOW(a_uncal_rest_unknown, clock, reset, !rsp_empty && !rsp_calibrated,
                    rsp_rest_level == trcm_pkg::REST_UNKNOWN)
   `TRCM_ASSERT_NOW(a_armed_needs_cal, clock, reset, !rsp_empty && rsp_armed, rsp_calibrated)
   `TRCM_ASSERT_NOW(a_no_travel_no_drive, clock, reset, !rsp_empty && rsp_travel == '0,
                    rsp_current_target_ma == '0 && rsp_speed_target_rpm == '0)

endmodule

// ===== bench/trigger_rest_calibration_map_checker.sv =====
// checker for the trigger rest calibration map unit: predicts every result and compares it
`timescale 1ns / 1ps

module trigger_rest_calibration_map_checker
   import trcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_cmd,
   input  logic [7:0]  req_sample,
   input  logic [31:0] req_time_ms,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic        rsp_calibrated,
   input  logic [7:0]  rsp_rest_level,
   input  logic [7:0]  rsp_effective,
   input  logic        rsp_armed,
   input  logic [7:0]  rsp_travel,
   input  logic [15:0] rsp_current_target_ma,
   input  logic [15:0] rsp_speed_target_rpm,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          waiting_count
);

   cfg_type     regs;
   logic        cal_done;
   logic [7:0]  rest;
   logic        zrun_open;
   logic [31:0] zrun_t0;
   logic        win_open;
   logic [31:0] win_t0;
   logic [7:0]  win_lo;
   logic [7:0]  win_hi;
   rsp_type     expected_q[$];
   int          errors = 0;
   int          waiting = 0;

   assign mismatch_count = errors;
   assign waiting_count  = waiting;

   task automatic load_defaults();
      regs.rest_margin       = RST_REST_MARGIN;
      regs.arm_threshold     = RST_ARM_THRESHOLD;
      regs.zero_rest_arm_raw = RST_ZERO_REST_ARM_RAW;
      regs.stable_spread     = RST_STABLE_SPREAD;
      regs.calib_window_ms   = RST_CALIB_WINDOW_MS;
      regs.zero_rest_ms      = RST_ZERO_REST_MS;
      regs.max_current_ma    = RST_MAX_CURRENT_MA;
      regs.max_speed_rpm     = RST_MAX_SPEED_RPM;
   endtask

   task automatic clear_cal();
      cal_done  = 1'b0;
      rest      = REST_UNKNOWN;
      zrun_open = 1'b0;
      zrun_t0   = '0;
      win_open  = 1'b0;
      win_t0    = '0;
      win_lo    = 8'd255;
      win_hi    = 8'd0;
   endtask

   task automatic settle_rest(input logic [7:0] lvl);
      rest      = lvl;
      cal_done  = 1'b1;
      zrun_open = 1'b0;
      win_open  = 1'b0;
   endtask

   task automatic open_win(input logic [7:0] s, input logic [31:0] t);
      win_open = 1'b1;
      win_t0   = t;
      win_lo   = s;
      win_hi   = s;
   endtask

   task automatic track_window(input logic [7:0] s, input logic [31:0] t);
      int unsigned sv, sp, lo, hi;
      logic [31:0] held;
      sv = s;
      sp = regs.stable_spread;
      lo = win_lo;
      hi = win_hi;
      if (!win_open || sv + sp < lo || sv > hi + sp) begin
         open_win(s, t);
      end else begin
         if (sv < lo) win_lo = s;
         if (sv > hi) win_hi = s;
         held = t - win_t0;
         if (held >= {16'd0, regs.calib_window_ms}) begin
            if (int'(win_hi) - int'(win_lo) <= int'(sp) && win_hi <= STABLE_MAX_IDLE)
               settle_rest(win_lo);
            else
               win_open = 1'b0;
         end
      end
   endtask

   task automatic update_cal(input logic [7:0] s, input logic [31:0] t);
      int unsigned gate, rv;
      logic [31:0] held;
      if (cal_done) begin
         rv   = rest;
         gate = rv + regs.rest_margin + GATE_PAD;
         if (gate > FULL_SCALE) gate = FULL_SCALE;
         if (s <= gate && !(rest == 8'd0 && s == 8'd0))
            rest = 8'((rv * 31 + s) / 32);
      end else if (s == 8'd0) begin
         win_open = 1'b0;
         held = t - zrun_t0;
         if (!zrun_open) begin
            zrun_open = 1'b1;
            zrun_t0   = t;
         end else if (held >= {16'd0, regs.zero_rest_ms}) begin
            settle_rest(8'd0);
         end
      end else begin
         zrun_open = 1'b0;
         if (s >= ANALOG_REST_MIN) track_window(s, t);
      end
   endtask

   task automatic predict_result(input logic cmd, input logic [7:0] s, input logic [31:0] t,
                                 output rsp_type r);
      int unsigned sv, rv, base, eff, trav, flr, rng, cur, spd;
      logic zr, arm;
      if (cmd == CMD_RESTART) clear_cal();
      else update_cal(s, t);
      sv   = s;
      rv   = rest;
      base = rv + regs.rest_margin;
      eff  = (sv <= base) ? 0 : sv - base;
      if (eff > FULL_SCALE) eff = FULL_SCALE;
      zr = cal_done && rest == 8'd0;
      if (!cal_done)
         arm = 1'b0;
      else if (rest == 8'd0)
         arm = sv >= regs.zero_rest_arm_raw;
      else
         arm = eff >= regs.arm_threshold;
      if (zr)
         trav = (sv <= regs.zero_rest_arm_raw) ? 0 : sv - regs.zero_rest_arm_raw;
      else
         trav = eff;
      flr = zr ? 0 : regs.arm_threshold;
      cur = 0;
      spd = 0;
      if (trav >= flr) begin
         rng = FULL_SCALE - flr;
         if (rng != 0) begin
            cur = (trav - flr) * regs.max_current_ma / rng;
            spd = (trav - flr) * regs.max_speed_rpm / rng;
         end
      end
      r.calibrated        = cal_done;
      r.rest_level        = rest;
      r.effective         = 8'(eff);
      r.armed             = arm;
      r.travel            = 8'(trav);
      r.current_target_ma = 16'(cur);
      r.speed_target_rpm  = 16'(spd);
   endtask

   function automatic void check_field(input string name, input int unsigned want_v,
                                       input int unsigned seen_v);
      if (want_v != seen_v) begin
         errors++;
         $error("%s: expected %0d, actual %0d", name, want_v, seen_v);
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want, seen;
      if (reset) begin
         load_defaults();
         clear_cal();
         expected_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_q.size() == 0) begin
               errors++;
               $error("result with no item waiting");
            end else begin
               want = expected_q.pop_front();
               check_field("calibrated", want.calibrated, rsp_calibrated);
               check_field("rest_level", want.rest_level, rsp_rest_level);
               check_field("effective", want.effective, rsp_effective);
               check_field("armed", want.armed, rsp_armed);
               check_field("travel", want.travel, rsp_travel);
               check_field("current_target_ma", want.current_target_ma,
                           rsp_current_target_ma);
               check_field("speed_target_rpm", want.speed_target_rpm, rsp_speed_target_rpm);
            end
         end
         if (req_push && !req_full) begin
            predict_result(req_cmd, req_sample, req_time_ms, seen);
            expected_q.push_back(seen);
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_REST_MARGIN:       regs.rest_margin       = csr_wdata[7:0];
               CSR_ARM_THRESHOLD:     regs.arm_threshold     = csr_wdata[7:0];
               CSR_ZERO_REST_ARM_RAW: regs.zero_rest_arm_raw = csr_wdata[7:0];
               CSR_STABLE_SPREAD:     regs.stable_spread     = csr_wdata[7:0];
               CSR_CALIB_WINDOW_MS:   regs.calib_window_ms   = csr_wdata;
               CSR_ZERO_REST_MS:      regs.zero_rest_ms      = csr_wdata;
               CSR_MAX_CURRENT_MA:    regs.max_current_ma    = csr_wdata;
               CSR_MAX_SPEED_RPM:     regs.max_speed_rpm     = csr_wdata;
               default: ;
            endcase
         end
      end
      waiting <= expected_q.size();
   end

endmodule

// ===== bench/trigger_rest_calibration_map_unit_tb.sv =====
// testbench top for the trigger rest calibration map unit: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module trigger_rest_calibration_map_unit_tb;
   import trcm_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_cmd = CMD_SAMPLE;
   logic [7:0]  req_sample = 8'd0;
   logic [31:0] req_time_ms = 32'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_calibrated;
   logic [7:0]  rsp_rest_level;
   logic [7:0]  rsp_effective;
   logic        rsp_armed;
   logic [7:0]  rsp_travel;
   logic [15:0] rsp_current_target_ma;
   logic [15:0] rsp_speed_target_rpm;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = CSR_REST_MARGIN;
   logic [15:0] csr_wdata = 16'd0;

   int          fail_count;
   int          pending;
   int          idle_cycles = 0;
   int          sent = 0;
   bit          calm = 1'b0;
   logic [31:0] now_ms = 32'd0;
   cfg_type     live;

   trigger_rest_calibration_map_unit uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_cmd               (req_cmd),
      .req_sample            (req_sample),
      .req_time_ms           (req_time_ms),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_calibrated        (rsp_calibrated),
      .rsp_rest_level        (rsp_rest_level),
      .rsp_effective         (rsp_effective),
      .rsp_armed             (rsp_armed),
      .rsp_travel            (rsp_travel),
      .rsp_current_target_ma (rsp_current_target_ma),
      .rsp_speed_target_rpm  (rsp_speed_target_rpm),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   trigger_rest_calibration_map_checker map_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_cmd               (req_cmd),
      .req_sample            (req_sample),
      .req_time_ms           (req_time_ms),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_calibrated        (rsp_calibrated),
      .rsp_rest_level        (rsp_rest_level),
      .rsp_effective         (rsp_effective),
      .rsp_armed             (rsp_armed),
      .rsp_travel            (rsp_travel),
      .rsp_current_target_ma (rsp_current_target_ma),
      .rsp_speed_target_rpm  (rsp_speed_target_rpm),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .mismatch_count        (fail_count),
      .waiting_count         (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : drain_side
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_regs(input logic [7:0] margin, input logic [7:0] arm,
                           input logic [7:0] zraw, input logic [7:0] spread,
                           input logic [15:0] window, input logic [15:0] zero_ms,
                           input logic [15:0] cur_max, input logic [15:0] spd_max);
      live.rest_margin       = margin;
      live.arm_threshold     = arm;
      live.zero_rest_arm_raw = zraw;
      live.stable_spread     = spread;
      live.calib_window_ms   = window;
      live.zero_rest_ms      = zero_ms;
      live.max_current_ma    = cur_max;
      live.max_speed_rpm     = spd_max;
      write_reg(CSR_REST_MARGIN, {8'd0, margin});
      write_reg(CSR_ARM_THRESHOLD, {8'd0, arm});
      write_reg(CSR_ZERO_REST_ARM_RAW, {8'd0, zraw});
      write_reg(CSR_STABLE_SPREAD, {8'd0, spread});
      write_reg(CSR_CALIB_WINDOW_MS, window);
      write_reg(CSR_ZERO_REST_MS, zero_ms);
      write_reg(CSR_MAX_CURRENT_MA, cur_max);
      write_reg(CSR_MAX_SPEED_RPM, spd_max);
   endtask

   task automatic send_item(input logic cmd, input logic [7:0] s, input logic [31:0] t);
      int gap;
      if ($urandom_range(0, 39) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_cmd     <= cmd;
      req_sample  <= s;
      req_time_ms <= t;
      do @(posedge clock); while (req_full);
      sent++;
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic zero_session();
      int unsigned span_ms, step;
      int count;
      logic [7:0] s;
      span_ms = 0;
      count = 0;
      send_item(CMD_RESTART, 8'($urandom), now_ms);
      do begin
         step = $urandom_range(0, live.zero_rest_ms / 3 + 1);
         now_ms += step;
         span_ms += step;
         s = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
         send_item(CMD_SAMPLE, s, now_ms);
         count++;
      end while ((span_ms <= live.zero_rest_ms || count < 2) && count < 14);
   endtask

   task automatic analog_session();
      int unsigned span_ms, step, lvl, jit, v;
      int count;
      span_ms = 0;
      count = 0;
      lvl = $urandom_range(1, 64);
      jit = (live.stable_spread < 8) ? live.stable_spread : 8;
      send_item(CMD_RESTART, 8'($urandom), now_ms);
      do begin
         step = $urandom_range(0, live.calib_window_ms / 3 + 1);
         now_ms += step;
         span_ms += step;
         v = lvl + $urandom_range(0, jit);
         if ($urandom_range(0, 11) == 0) v = $urandom_range(0, 255);
         send_item(CMD_SAMPLE, 8'(v), now_ms);
         count++;
      end while ((span_ms <= live.calib_window_ms || count < 2) && count < 14);
   endtask

   task automatic tracking_run();
      logic [7:0] s;
      repeat ($urandom_range(4, 14)) begin
         now_ms += $urandom_range(0, 300);
         case ($urandom_range(0, 3))
            0:       s = 8'd0;
            1:       s = 8'($urandom_range(0, 40));
            default: s = 8'($urandom);
         endcase
         send_item(CMD_SAMPLE, s, now_ms);
      end
   endtask

   task automatic noise_run();
      logic cmd;
      repeat (5) begin
         cmd = ($urandom_range(0, 7) == 0) ? CMD_RESTART : CMD_SAMPLE;
         if ($urandom_range(0, 1) == 0) now_ms = $urandom;
         else now_ms += $urandom_range(0, 70000);
         send_item(cmd, 8'($urandom), now_ms);
      end
   endtask

   task automatic random_phase(input int count);
      int start;
      start = sent;
      if ($urandom_range(0, 1) == 0) now_ms = $urandom;
      while (sent - start < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               zero_session();
               tracking_run();
            end
            4, 5, 6, 7: begin
               analog_session();
               tracking_run();
            end
            8:       tracking_run();
            default: noise_run();
         endcase
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero rest: run of zeros, then arming on raw level
      send_item(CMD_RESTART, 8'd255, 32'd0);
      send_item(CMD_SAMPLE, 8'd0, 32'd0);
      send_item(CMD_SAMPLE, 8'd0, 32'd250);
      send_item(CMD_SAMPLE, 8'd0, 32'd500);
      send_item(CMD_SAMPLE, 8'd0, 32'd510);
      send_item(CMD_SAMPLE, 8'd20, 32'd520);
      send_item(CMD_SAMPLE, 8'd19, 32'd530);
      send_item(CMD_SAMPLE, 8'd255, 32'd540);
      send_item(CMD_SAMPLE, 8'd12, 32'd550);
      // analog rest across a timestamp wrap
      send_item(CMD_RESTART, 8'd0, 32'hFFFF_FF00);
      send_item(CMD_SAMPLE, 8'd5, 32'hFFFF_FF00);
      send_item(CMD_SAMPLE, 8'd8, 32'hFFFF_FFFF);
      send_item(CMD_SAMPLE, 8'd6, 32'h0000_01F4);
      send_item(CMD_SAMPLE, 8'd255, 32'h0000_0200);
      send_item(CMD_SAMPLE, 8'd33, 32'h0000_0210);
      send_item(CMD_SAMPLE, 8'd32, 32'h0000_0220);
      send_item(CMD_SAMPLE, 8'd17, 32'h0000_0230);
      send_item(CMD_SAMPLE, 8'd18, 32'h0000_0240);
      // window peak too high, spread break, zero closing the window
      send_item(CMD_RESTART, 8'd100, 32'h0000_1000);
      send_item(CMD_SAMPLE, 8'd70, 32'h0000_1000);
      send_item(CMD_SAMPLE, 8'd72, 32'h0000_1100);
      send_item(CMD_SAMPLE, 8'd71, 32'h0000_1300);
      send_item(CMD_SAMPLE, 8'd80, 32'h0000_1400);
      send_item(CMD_SAMPLE, 8'd100, 32'h0000_1410);
      send_item(CMD_SAMPLE, 8'd0, 32'h0000_1420);
      wait_idle();

      set_regs(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
      random_phase(PHASE_ITEMS);
      wait_idle();

      set_regs(8'd255, 8'd254, 8'd254, 8'd255, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
      random_phase(PHASE_ITEMS);
      wait_idle();

      repeat (3) begin
         set_regs(8'($urandom_range(0, 16)), 8'($urandom_range(0, 60)),
                  8'($urandom_range(0, 60)), 8'($urandom_range(0, 12)),
                  16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)),
                  16'($urandom), 16'($urandom));
         random_phase(PHASE_ITEMS);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== trigger_rest_calibration_map_unit.f =====
+incdir+rtl
rtl/trcm_pkg.sv
rtl/trcm_fifo.sv
rtl/trcm_front.sv
rtl/trcm_back.sv
rtl/trigger_rest_calibration_map_unit.sv
bench/trigger_rest_calibration_map_checker.sv
bench/trigger_rest_calibration_map_unit_tb.sv
